[src/indexed_max_priority_table_core_assert.svh]
// Assertion macros shared by the table core modules.
`ifndef INDEXED_MAX_PRIORITY_TABLE_CORE_ASSERT_SVH
`define INDEXED_MAX_PRIORITY_TABLE_CORE_ASSERT_SVH
`ifndef SYNTH
// Check a property once reset is released.
`define IMPT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property whose consequent holds in the cycle after its antecedent, once reset is released.
`define IMPT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define IMPT_ASSERT(label, clk, rst_n, prop, msg)
`define IMPT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

[src/impt_pkg.sv]
package impt_pkg;

  localparam int MODE_W       = 3;
  localparam int ID_W         = 8;
  localparam int PRIO_W       = 16;
  localparam int PAY_W        = 32;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 256;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD     = 3'd0,
    MODE_PROMOTE = 3'd1,
    MODE_POP     = 3'd2,
    MODE_PEEK    = 3'd3,
    MODE_READ    = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_BAD   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_SCAN,
    S_SCAN_END,
    S_FETCH,
    S_FINISH
  } state_t;

  // Read address source
  typedef enum logic [1:0] {
    RD_ID,
    RD_SCAN,
    RD_BEST
  } rd_sel_t;

  // Entry update kind
  typedef enum logic [1:0] {
    WR_CLEAR,
    WR_ADD,
    WR_PROMOTE,
    WR_POP
  } wr_sel_t;

  // Result composition
  typedef enum logic [2:0] {
    RES_NONE,
    RES_ADD,
    RES_FULL,
    RES_BAD,
    RES_EMPTY,
    RES_PROMOTE,
    RES_READ,
    RES_MAX
  } res_kind_t;

  typedef struct packed {
    logic      latch_in;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      wr_meta_en;
    logic      wr_pay_en;
    wr_sel_t   wr_sel;
    logic      clear_step;
    logic      scan_start;
    logic      scan_step;
    logic      hdl_inc;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      res_load;
    res_kind_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  empty;
    logic  id_in_range;
    logic  rd_live;
    logic  clear_last;
    logic  scan_last;
    logic  out_free;
  } dp_sts_t;

endpackage

[src/impt_if.sv]
interface impt_in_if;
  logic                          valid;
  logic                          ready;
  logic [impt_pkg::MODE_W-1:0]   mode;
  logic [impt_pkg::ID_W-1:0]     item_id;
  logic [impt_pkg::PAY_W-1:0]    payload;

  modport source (output valid, output mode, output item_id, output payload, input ready);
  modport sink   (input valid, input mode, input item_id, input payload, output ready);
endinterface

interface impt_out_if;
  logic                          valid;
  logic                          ready;
  logic [impt_pkg::ID_W-1:0]     out_id;
  logic [impt_pkg::PRIO_W-1:0]   out_priority;
  logic [impt_pkg::PAY_W-1:0]    out_payload;
  logic                          out_live;
  logic [impt_pkg::STATUS_W-1:0] status;

  modport source (output valid, output out_id, output out_priority, output out_payload,
                  output out_live, output status, input ready);
  modport sink   (input valid, input out_id, input out_priority, input out_payload,
                  input out_live, input status, output ready);
endinterface

[src/impt_ctrl.sv]
`include "indexed_max_priority_table_core_assert.svh"

module impt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  impt_pkg::dp_sts_t sts,
  output impt_pkg::dp_cmd_t cmd
);

  impt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= impt_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      impt_pkg::S_CLEAR: begin
        cmd.wr_meta_en = 1'b1;
        cmd.wr_sel     = impt_pkg::WR_CLEAR;
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = impt_pkg::S_IDLE;
        end
      end
      impt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = impt_pkg::S_EXEC;
        end
      end
      impt_pkg::S_EXEC: begin
        case (sts.mode) inside
          impt_pkg::MODE_ADD: begin
            if (sts.out_free) begin
              cmd.res_load = 1'b1;
              state_nxt    = impt_pkg::S_IDLE;
              if (sts.full) begin
                cmd.res_kind = impt_pkg::RES_FULL;
              end else begin
                cmd.res_kind   = impt_pkg::RES_ADD;
                cmd.wr_meta_en = 1'b1;
                cmd.wr_pay_en  = 1'b1;
                cmd.wr_sel     = impt_pkg::WR_ADD;
                cmd.hdl_inc    = 1'b1;
                cmd.cnt_inc    = 1'b1;
              end
            end
          end
          impt_pkg::MODE_PROMOTE, impt_pkg::MODE_READ: begin
            if (sts.id_in_range) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = impt_pkg::RD_ID;
              state_nxt  = impt_pkg::S_CHECK;
            end else if (sts.out_free) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = impt_pkg::RES_BAD;
              state_nxt    = impt_pkg::S_IDLE;
            end
          end
          impt_pkg::MODE_POP, impt_pkg::MODE_PEEK: begin
            if (!sts.empty) begin
              cmd.scan_start = 1'b1;
              state_nxt      = impt_pkg::S_SCAN;
            end else if (sts.out_free) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = impt_pkg::RES_EMPTY;
              state_nxt    = impt_pkg::S_IDLE;
            end
          end
          default: begin
            if (sts.out_free) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = impt_pkg::RES_NONE;
              state_nxt    = impt_pkg::S_IDLE;
            end
          end
        endcase
      end
      impt_pkg::S_CHECK: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = impt_pkg::S_IDLE;
          if (!sts.rd_live) begin
            cmd.res_kind = impt_pkg::RES_BAD;
          end else if (sts.mode == impt_pkg::MODE_PROMOTE) begin
            cmd.res_kind   = impt_pkg::RES_PROMOTE;
            cmd.wr_meta_en = 1'b1;
            cmd.wr_sel     = impt_pkg::WR_PROMOTE;
          end else begin
            cmd.res_kind = impt_pkg::RES_READ;
          end
        end
      end
      impt_pkg::S_SCAN: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = impt_pkg::RD_SCAN;
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = impt_pkg::S_SCAN_END;
        end
      end
      impt_pkg::S_SCAN_END: begin
        state_nxt = impt_pkg::S_FETCH;
      end
      impt_pkg::S_FETCH: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = impt_pkg::RD_BEST;
        state_nxt  = impt_pkg::S_FINISH;
      end
      impt_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = impt_pkg::RES_MAX;
          state_nxt    = impt_pkg::S_IDLE;
          if (sts.mode == impt_pkg::MODE_POP) begin
            cmd.wr_meta_en = 1'b1;
            cmd.wr_sel     = impt_pkg::WR_POP;
            cmd.cnt_dec    = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = impt_pkg::S_IDLE;
      end
    endcase
  end

  `IMPT_ASSERT_NEXT(a_one_txn, clk, rst_n, in_valid && in_ready, !in_ready, "second transaction taken while busy")
  `IMPT_ASSERT(a_cmd_excl, clk, rst_n, $onehot0({cmd.latch_in, cmd.res_load, cmd.scan_step, cmd.clear_step}), "conflicting commands")
  `IMPT_ASSERT(a_ready_idle, clk, rst_n, in_ready == (state_r == impt_pkg::S_IDLE), "ready outside idle")

endmodule

[src/impt_dp.sv]
`include "indexed_max_priority_table_core_assert.svh"

module impt_dp #(
  parameter int CAPACITY = impt_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [impt_pkg::MODE_W-1:0]     in_mode,
  input  logic [impt_pkg::ID_W-1:0]       in_item_id,
  input  logic [impt_pkg::PAY_W-1:0]      in_payload,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [impt_pkg::ID_W-1:0]       out_id,
  output logic [impt_pkg::PRIO_W-1:0]     out_priority,
  output logic [impt_pkg::PAY_W-1:0]      out_payload,
  output logic                            out_live,
  output logic [impt_pkg::STATUS_W-1:0]   out_status,
  input  impt_pkg::dp_cmd_t               cmd,
  output impt_pkg::dp_sts_t               sts
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > impt_pkg::ID_W) ? CW : impt_pkg::ID_W;
  localparam int PW   = impt_pkg::PRIO_W;
  localparam int MW   = PW + 1;

  // Entry store: live mark on top of the priority, payload apart
  logic [MW-1:0]              meta_mem [CAPACITY];
  logic [impt_pkg::PAY_W-1:0] pay_mem  [CAPACITY];
  logic [MW-1:0]              meta_rd_r;
  logic [impt_pkg::PAY_W-1:0] pay_rd_r;

  logic [impt_pkg::MODE_W-1:0] mode_r;
  logic [impt_pkg::ID_W-1:0]   id_r;
  logic [impt_pkg::PAY_W-1:0]  pay_r;
  logic [CW-1:0]               hdl_r;
  logic [CW-1:0]               cnt_r;
  logic [AW-1:0]               clr_idx_r;
  logic [AW-1:0]               scan_idx_r;
  logic                        cmp_en_r;
  logic [AW-1:0]               cmp_idx_r;
  logic                        found_r;
  logic [AW-1:0]               best_idx_r;
  logic [PW-1:0]               best_prio_r;

  logic                        out_valid_r;
  logic [impt_pkg::ID_W-1:0]   out_id_r;
  logic [PW-1:0]               out_prio_r;
  logic [impt_pkg::PAY_W-1:0]  out_pay_r;
  logic                        out_live_r;
  impt_pkg::status_t           out_status_r;

  logic [impt_pkg::ID_W-1:0]   out_id_nxt;
  logic [PW-1:0]               out_prio_nxt;
  logic [impt_pkg::PAY_W-1:0]  out_pay_nxt;
  logic                        out_live_nxt;
  impt_pkg::status_t           out_status_nxt;

  logic [CMPW-1:0] id_ext;
  logic [CMPW-1:0] hdl_ext;
  logic [CMPW-1:0] best_ext;
  logic [CMPW-1:0] hdl_id_ext;
  logic [AW-1:0]   id_addr;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic [MW-1:0]   wr_data;
  logic [PW-1:0]   rd_prio;
  logic [PW-1:0]   prio_inc;
  logic            out_free;
  logic            take_best;

  assign id_ext     = CMPW'(id_r);
  assign hdl_ext    = CMPW'(hdl_r);
  assign best_ext   = CMPW'(best_idx_r);
  assign hdl_id_ext = CMPW'(hdl_r);
  assign id_addr    = id_ext[AW-1:0];
  assign rd_prio    = meta_rd_r[PW-1:0];
  assign prio_inc   = (rd_prio == {PW{1'b1}}) ? rd_prio : rd_prio + PW'(1);
  assign out_free   = !out_valid_r || out_ready;
  assign take_best  = cmp_en_r && meta_rd_r[PW] && (!found_r || rd_prio >= best_prio_r);

  always_comb begin
    case (cmd.rd_sel)
      impt_pkg::RD_ID:   rd_addr = id_addr;
      impt_pkg::RD_SCAN: rd_addr = scan_idx_r;
      default:           rd_addr = best_idx_r;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      impt_pkg::WR_CLEAR: begin
        wr_addr = clr_idx_r;
        wr_data = '0;
      end
      impt_pkg::WR_ADD: begin
        wr_addr = hdl_r[AW-1:0];
        wr_data = {1'b1, {PW{1'b0}}};
      end
      impt_pkg::WR_PROMOTE: begin
        wr_addr = id_addr;
        wr_data = {1'b1, prio_inc};
      end
      default: begin
        wr_addr = best_idx_r;
        wr_data = {1'b0, best_prio_r};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_meta_en) begin
      meta_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      meta_rd_r <= meta_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_pay_en) begin
      pay_mem[wr_addr] <= pay_r;
    end
    if (cmd.rd_en) begin
      pay_rd_r <= pay_mem[rd_addr];
    end
  end

  // Captured transaction
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      mode_r <= in_mode;
      id_r   <= in_item_id;
      pay_r  <= in_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdl_r     <= '0;
      cnt_r     <= '0;
      clr_idx_r <= '0;
      cmp_en_r  <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      if (cmd.hdl_inc) begin
        hdl_r <= hdl_r + CW'(1);
      end
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.clear_step) begin
        clr_idx_r <= clr_idx_r + AW'(1);
      end
      cmp_en_r <= cmd.rd_en && (cmd.rd_sel == impt_pkg::RD_SCAN);
      if (cmd.scan_start) begin
        found_r <= 1'b0;
      end else if (take_best) begin
        found_r <= 1'b1;
      end
    end
  end

  // Scan bookkeeping; ">=" with rising index sends ties to the larger handle
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + AW'(1);
    end
    cmp_idx_r <= scan_idx_r;
    if (take_best) begin
      best_idx_r  <= cmp_idx_r;
      best_prio_r <= rd_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Compose the result; fields not named by a kind stay zero
  always_comb begin
    out_id_nxt     = '0;
    out_prio_nxt   = '0;
    out_pay_nxt    = '0;
    out_live_nxt   = 1'b0;
    out_status_nxt = impt_pkg::ST_OK;
    case (cmd.res_kind)
      impt_pkg::RES_ADD: begin
        out_id_nxt   = hdl_id_ext[impt_pkg::ID_W-1:0];
        out_live_nxt = 1'b1;
      end
      impt_pkg::RES_FULL: begin
        out_status_nxt = impt_pkg::ST_FULL;
      end
      impt_pkg::RES_BAD: begin
        out_id_nxt     = id_r;
        out_status_nxt = impt_pkg::ST_BAD;
      end
      impt_pkg::RES_EMPTY: begin
        out_status_nxt = impt_pkg::ST_EMPTY;
      end
      impt_pkg::RES_PROMOTE: begin
        out_id_nxt   = id_r;
        out_prio_nxt = prio_inc;
        out_live_nxt = 1'b1;
      end
      impt_pkg::RES_READ: begin
        out_id_nxt   = id_r;
        out_prio_nxt = rd_prio;
        out_pay_nxt  = pay_rd_r;
        out_live_nxt = 1'b1;
      end
      impt_pkg::RES_MAX: begin
        out_id_nxt   = best_ext[impt_pkg::ID_W-1:0];
        out_prio_nxt = best_prio_r;
        out_pay_nxt  = pay_rd_r;
        out_live_nxt = (impt_pkg::mode_t'(mode_r) != impt_pkg::MODE_POP);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_id_r     <= out_id_nxt;
      out_prio_r   <= out_prio_nxt;
      out_pay_r    <= out_pay_nxt;
      out_live_r   <= out_live_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_id       = out_id_r;
  assign out_priority = out_prio_r;
  assign out_payload  = out_pay_r;
  assign out_live     = out_live_r;
  assign out_status   = out_status_r;

  assign sts.mode        = impt_pkg::mode_t'(mode_r);
  assign sts.full        = (hdl_r == CW'(CAPACITY));
  assign sts.empty       = (cnt_r == '0);
  assign sts.id_in_range = (id_ext < hdl_ext);
  assign sts.rd_live     = meta_rd_r[PW];
  assign sts.clear_last  = (clr_idx_r == AW'(CAPACITY - 1));
  assign sts.scan_last   = (CW'(scan_idx_r) == hdl_r - CW'(1));
  assign sts.out_free    = out_free;

  `IMPT_ASSERT(a_cnt_le_hdl, clk, rst_n, cnt_r <= hdl_r, "live count above handle count")
  `IMPT_ASSERT(a_hdl_bound, clk, rst_n, hdl_r <= CW'(CAPACITY), "handle counter past capacity")
  `IMPT_ASSERT(a_res_slot, clk, rst_n, !cmd.res_load || !out_valid_r || out_ready, "result overwrites a held transaction")
  `IMPT_ASSERT_NEXT(a_pop_found, clk, rst_n, cmd.res_load && cmd.res_kind == impt_pkg::RES_MAX, out_status == impt_pkg::ST_OK, "max result without ok status")

endmodule

[src/indexed_max_priority_table_core.sv]
// Indexed max-priority table: CAPACITY entries of payload, priority and live mark,
// handles handed out from zero upward and never reused. One transaction is worked
// at a time; ready drops from acceptance until the result is loaded into the output
// register, and the next transaction may be taken while that result still waits.
// The result is loaded from the decode state for add, an unused mode, an empty pop or
// peek and an out-of-range handle; promote and read first read the entry; pop and
// peek scan the handles issued so far, then pass a settling state and fetch the best
// entry before the load. Ready rises the cycle after the load; a result held by a
// stalled receiver delays the load until the receiver frees the output register.
// Pop and peek are set by the scan, which reads one entry a cycle through the single
// read port of the entry store. After reset a clearing pass zeroes the live marks of
// all entries, during which no transaction is accepted.
module indexed_max_priority_table_core #(
  parameter int CAPACITY = impt_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  impt_in_if.sink           in_ch,
  impt_out_if.source        out_ch
);

  impt_pkg::dp_cmd_t cmd;
  impt_pkg::dp_sts_t sts;
  logic              in_ready;

  // Sequencer: clearing pass, decode, scan and result hand-off
  impt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Entry store, counters, scan registers and output register
  impt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mode      (in_ch.mode),
    .in_item_id   (in_ch.item_id),
    .in_payload   (in_ch.payload),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_id       (out_ch.out_id),
    .out_priority (out_ch.out_priority),
    .out_payload  (out_ch.out_payload),
    .out_live     (out_ch.out_live),
    .out_status   (out_ch.status),
    .cmd          (cmd),
    .sts          (sts)
  );

  // Hold ready low while a transaction is in work
  assign in_ch.ready = in_ready;

endmodule

[dv/tb_indexed_max_priority_table_core.sv]
module tb_indexed_max_priority_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Modes 5 to 7 are unused: the block answers them with an all-zero result.
  localparam logic [impt_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [impt_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  localparam logic [impt_pkg::PRIO_W-1:0] PRIO_TOP = '1;

  // Promotes applied in a row to one entry.
  localparam int PROMOTE_STEPS = 16;

  localparam int RANDOM_OPS = 220;

  // Pops issued once the table is full.
  localparam int DRAIN_POPS = 16;

  // Worst case: every promote waits out long receiver stalls, every pop or peek
  // scans the whole table behind a long sender gap, plus the clearing pass.
  localparam int CYCLE_LIMIT = 4_000_000;

  // Expected contents of one result transaction.
  typedef struct packed {
    logic [impt_pkg::ID_W-1:0]   id;
    logic [impt_pkg::PRIO_W-1:0] prio;
    logic [impt_pkg::PAY_W-1:0]  pay;
    logic                        live;
    impt_pkg::status_t           status;
  } table_answer_t;

  logic clk;
  logic rst_n;

  impt_in_if  in_if ();
  impt_out_if out_if ();

  indexed_max_priority_table_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  // Shadow copy of the table, updated at the moment each transaction is accepted.
  logic [impt_pkg::PAY_W-1:0]  tbl_payload [impt_pkg::CAPACITY_DEF];
  logic [impt_pkg::PRIO_W-1:0] tbl_prio    [impt_pkg::CAPACITY_DEF];
  logic                        tbl_live    [impt_pkg::CAPACITY_DEF];
  int                          handles_issued;
  int                          live_total;

  table_answer_t pending_answers [$];

  int fault_count;
  int cycle_count;

  // Sender pacing: bursts of back-to-back transactions separated by gaps.
  int burst_left;
  bit gaps_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Global watchdog.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("FAIL indexed_max_priority_table_core");
        $finish;
      end
    end
  end

  // Receiver: phases of random length, each with its own stall rate
  // (never, sometimes, mostly).
  initial begin
    int run_left;
    int stall_pct;
    out_if.ready = 1'b0;
    run_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        run_left = $urandom_range(5, 60);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 80;
        endcase
      end
      run_left--;
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic bit handle_is_live(logic [impt_pkg::ID_W-1:0] id);
    return (int'(id) < handles_issued) && tbl_live[id];
  endfunction

  // Apply one operation to the shadow table and return the answer it must give.
  function automatic table_answer_t compute_table_answer(
      logic [impt_pkg::MODE_W-1:0] op,
      logic [impt_pkg::ID_W-1:0]   id,
      logic [impt_pkg::PAY_W-1:0]  pay);
    table_answer_t ans;
    int            best;
    bit            found;
    ans = '0;
    best = 0;
    found = 1'b0;
    case (op)
      impt_pkg::MODE_ADD: begin
        if (handles_issued >= impt_pkg::CAPACITY_DEF) begin
          ans.status = impt_pkg::ST_FULL;
        end else begin
          tbl_payload[handles_issued] = pay;
          tbl_prio[handles_issued] = '0;
          tbl_live[handles_issued] = 1'b1;
          ans.id = impt_pkg::ID_W'(handles_issued);
          ans.live = 1'b1;
          handles_issued++;
          live_total++;
        end
      end
      impt_pkg::MODE_PROMOTE: begin
        ans.id = id;
        if (!handle_is_live(id)) begin
          ans.status = impt_pkg::ST_BAD;
        end else begin
          // Saturate at the top value; status stays ok.
          if (tbl_prio[id] != PRIO_TOP) tbl_prio[id] = tbl_prio[id] + 1'b1;
          ans.prio = tbl_prio[id];
          ans.live = 1'b1;
        end
      end
      impt_pkg::MODE_POP, impt_pkg::MODE_PEEK: begin
        if (live_total == 0) begin
          ans.status = impt_pkg::ST_EMPTY;
        end else begin
          // Highest priority wins; ">=" hands ties to the larger handle.
          for (int i = 0; i < impt_pkg::CAPACITY_DEF; i++) begin
            if (tbl_live[i] && (!found || tbl_prio[i] >= tbl_prio[best])) begin
              best = i;
              found = 1'b1;
            end
          end
          ans.id = impt_pkg::ID_W'(best);
          ans.prio = tbl_prio[best];
          ans.pay = tbl_payload[best];
          ans.live = (op == impt_pkg::MODE_PEEK);
          if (op == impt_pkg::MODE_POP) begin
            tbl_live[best] = 1'b0;
            live_total--;
          end
        end
      end
      impt_pkg::MODE_READ: begin
        ans.id = id;
        if (!handle_is_live(id)) begin
          ans.status = impt_pkg::ST_BAD;
        end else begin
          ans.prio = tbl_prio[id];
          ans.pay = tbl_payload[id];
          ans.live = 1'b1;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Drive one transaction, hold it until accepted, then record its answer.
  // Valid is left high at exit unless a gap follows, so a call in the same
  // time step just replaces the payload.
  task automatic send_op(logic [impt_pkg::MODE_W-1:0] op, logic [impt_pkg::ID_W-1:0] id,
                         logic [impt_pkg::PAY_W-1:0] pay);
    int            gap;
    table_answer_t ans;
    in_if.valid   <= 1'b1;
    in_if.mode    <= op;
    in_if.item_id <= id;
    in_if.payload <= pay;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    ans = compute_table_answer(op, id, pay);
    pending_answers = {pending_answers, ans};
    if (burst_left > 0) begin
      burst_left--;
    end else if (gaps_on) begin
      // Next burst is sometimes long, giving stretches with no idling at all.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      // Mostly short gaps; some long enough to land in the middle of a scan.
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 280) : $urandom_range(1, 5);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every outstanding answer has come back.
  task automatic wait_answers_drained();
    in_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Pick a live handle where one can be found quickly, else any handle.
  function automatic logic [impt_pkg::ID_W-1:0] pick_live_handle();
    logic [impt_pkg::ID_W-1:0] h;
    h = impt_pkg::ID_W'($urandom_range(0, impt_pkg::CAPACITY_DEF - 1));
    if (handles_issued == 0) return h;
    for (int tries = 0; tries < 8; tries++) begin
      h = impt_pkg::ID_W'($urandom_range(0, handles_issued - 1));
      if (tbl_live[h]) return h;
    end
    return h;
  endfunction

  // Compare every accepted result against the oldest outstanding answer.
  always @(posedge clk) begin
    table_answer_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_answers.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("[%0t] unexpected result: id=%0h prio=%0h pay=%0h live=%0b status=%0d",
                   $realtime, out_if.out_id, out_if.out_priority, out_if.out_payload,
                   out_if.out_live, out_if.status);
      end else begin
        want = pending_answers.pop_front();
        if (out_if.out_id !== want.id || out_if.out_priority !== want.prio ||
            out_if.out_payload !== want.pay || out_if.out_live !== want.live ||
            out_if.status !== want.status) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("[%0t] result mismatch", $realtime);
            $display("  expected id=%0h prio=%0h pay=%0h live=%0b status=%0d",
                     want.id, want.prio, want.pay, want.live, want.status);
            $display("  actual   id=%0h prio=%0h pay=%0h live=%0b status=%0d",
                     out_if.out_id, out_if.out_priority, out_if.out_payload,
                     out_if.out_live, out_if.status);
          end
        end
      end
    end
  end

  // Empty table, bad handles, unused modes, tie-break and pop of a promoted entry.
  task automatic test_directed_corners();
    send_op(impt_pkg::MODE_PEEK, '0, '0);
    send_op(impt_pkg::MODE_POP, '0, '0);
    send_op(impt_pkg::MODE_READ, '0, '0);
    send_op(impt_pkg::MODE_PROMOTE, '1, '1);
    for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
      send_op(impt_pkg::MODE_W'(m), '1, '1);
    send_op(impt_pkg::MODE_ADD, '1, '0);
    send_op(impt_pkg::MODE_ADD, '0, '1);
    send_op(impt_pkg::MODE_ADD, '0, 32'hA5A5_5A5A);
    // All at priority zero: the largest handle wins.
    send_op(impt_pkg::MODE_PEEK, '0, '0);
    send_op(impt_pkg::MODE_PROMOTE, 8'd0, '0);
    send_op(impt_pkg::MODE_PROMOTE, 8'd0, '0);
    send_op(impt_pkg::MODE_PROMOTE, 8'd1, '0);
    send_op(impt_pkg::MODE_READ, 8'd0, '0);
    send_op(impt_pkg::MODE_READ, 8'd1, '0);
    send_op(impt_pkg::MODE_READ, 8'd2, '0);
    // Handle not yet issued.
    send_op(impt_pkg::MODE_READ, 8'd3, '0);
    send_op(impt_pkg::MODE_POP, '0, '0);
    // Popped handle is dead for good.
    send_op(impt_pkg::MODE_READ, 8'd0, '0);
    send_op(impt_pkg::MODE_PROMOTE, 8'd0, '0);
    // Tie at priority one between handles 1 and 2.
    send_op(impt_pkg::MODE_PROMOTE, 8'd2, '0);
    send_op(impt_pkg::MODE_PEEK, '0, '0);
    send_op(impt_pkg::MODE_POP, '0, '0);
    send_op(impt_pkg::MODE_POP, '0, '0);
    send_op(impt_pkg::MODE_POP, '0, '0);
    wait_answers_drained();
  endtask

  // Promote one fresh entry many times back to back, then read and pop it.
  task automatic test_promote_run();
    logic [impt_pkg::ID_W-1:0] h;
    h = impt_pkg::ID_W'(handles_issued);
    gaps_on = 1'b0;
    send_op(impt_pkg::MODE_ADD, '0, $urandom);
    for (int n = 0; n < PROMOTE_STEPS; n++)
      send_op(impt_pkg::MODE_PROMOTE, h, '0);
    gaps_on = 1'b1;
    send_op(impt_pkg::MODE_READ, h, '0);
    send_op(impt_pkg::MODE_POP, '0, '0);
    wait_answers_drained();
  endtask

  // Mostly well-formed traffic on live handles, with some noise mixed in.
  task automatic test_random_traffic();
    int pick;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 28)
        send_op(impt_pkg::MODE_ADD, impt_pkg::ID_W'($urandom), $urandom);
      else if (pick < 50)
        send_op(impt_pkg::MODE_PROMOTE, pick_live_handle(), $urandom);
      else if (pick < 62)
        send_op(impt_pkg::MODE_POP, impt_pkg::ID_W'($urandom), $urandom);
      else if (pick < 72)
        send_op(impt_pkg::MODE_PEEK, impt_pkg::ID_W'($urandom), $urandom);
      else if (pick < 86)
        send_op(impt_pkg::MODE_READ, pick_live_handle(), $urandom);
      else if (pick < 94)
        send_op($urandom_range(0, 1) ? impt_pkg::MODE_PROMOTE : impt_pkg::MODE_READ,
                impt_pkg::ID_W'($urandom), $urandom);
      else
        send_op(impt_pkg::MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)),
                impt_pkg::ID_W'($urandom), $urandom);
    end
    wait_answers_drained();
  endtask

  // Use up every handle, hit the full table, then pop a batch off the top.
  task automatic test_fill_and_drain();
    while (handles_issued < impt_pkg::CAPACITY_DEF)
      send_op(impt_pkg::MODE_ADD, '0, $urandom);
    repeat (3) send_op(impt_pkg::MODE_ADD, '0, $urandom);
    send_op(impt_pkg::MODE_PROMOTE, '1, '0);
    send_op(impt_pkg::MODE_READ, '1, '0);
    send_op(impt_pkg::MODE_PEEK, '0, '0);
    repeat (DRAIN_POPS) send_op(impt_pkg::MODE_POP, '0, '0);
    send_op(impt_pkg::MODE_PEEK, '0, '0);
    send_op(impt_pkg::MODE_ADD, '0, '1);
    send_op(impt_pkg::MODE_PROMOTE, '1, '0);
    send_op(impt_pkg::MODE_READ, '0, '0);
    wait_answers_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.mode = impt_pkg::MODE_ADD;
    in_if.item_id = '0;
    in_if.payload = '0;
    fault_count = 0;
    handles_issued = 0;
    live_total = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    for (int i = 0; i < impt_pkg::CAPACITY_DEF; i++) begin
      tbl_payload[i] = '0;
      tbl_prio[i] = '0;
      tbl_live[i] = 1'b0;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // The clearing pass after reset is covered by the handshake wait.
    test_directed_corners();
    test_promote_run();
    test_random_traffic();
    test_fill_and_drain();

    // Allow for a full scan in case a stray result is still on its way.
    repeat (impt_pkg::CAPACITY_DEF + 20) @(posedge clk);
    if (fault_count == 0 && pending_answers.size() == 0)
      $display("PASS indexed_max_priority_table_core");
    else
      $display("FAIL indexed_max_priority_table_core");
    $finish;
  end

endmodule
